>>> sv/cpt_pkg.sv
// Shared types, codes and action table for the commit participant tracker.
`default_nettype none
package cpt_pkg;

  localparam int MAX_PARTICIPANTS = 16;
  localparam int IDX_W = $clog2(MAX_PARTICIPANTS);
  localparam int CNT_W = 5;

  localparam logic [2:0] PS_BAD       = 3'd0;
  localparam logic [2:0] PS_PREPARED  = 3'd1;
  localparam logic [2:0] PS_ABORTED   = 3'd2;
  localparam logic [2:0] PS_COMMITTED = 3'd3;
  localparam logic [2:0] PS_ACTIVE    = 3'd4;
  localparam logic [2:0] PS_READONLY  = 3'd5;
  localparam logic [2:0] PS_DIED      = 3'd6;

  localparam logic [2:0] OP_ACTIVATE = 3'd0;
  localparam logic [2:0] OP_VOTE     = 3'd1;
  localparam logic [2:0] OP_ACK      = 3'd2;
  localparam logic [2:0] OP_DIED     = 3'd3;
  localparam logic [2:0] OP_RECOVER  = 3'd4;
  localparam logic [2:0] OP_EVALUATE = 3'd5;

  localparam logic [1:0] VK_COMMIT    = 2'd0;
  localparam logic [1:0] VK_READ_ONLY = 2'd1;

  localparam logic [2:0] COORD_DONE   = 3'd0;
  localparam logic [2:0] COORD_VOTE   = 3'd1;
  localparam logic [2:0] COORD_ABORT  = 3'd2;
  localparam logic [2:0] COORD_COMMIT = 3'd3;
  localparam logic [2:0] COORD_WAIT   = 3'd4;

  localparam logic [0:0] REG_PROTOCOL_MODE     = 1'd0;
  localparam logic [0:0] REG_PARTICIPANT_COUNT = 1'd1;

  localparam logic [2:0] ACT_INC   = 3'd0;
  localparam logic [2:0] ACT_CHOKE = 3'd1;
  localparam logic [2:0] ACT_IGN   = 3'd2;
  localparam logic [2:0] ACT_MIX   = 3'd3;
  localparam logic [2:0] ACT_RETX  = 3'd4;

  typedef struct packed {
    logic       zero_on_death;
    logic [2:0] coordinator_state;
    logic [2:0] new_state;
    logic       ack_is_commit;
    logic [1:0] vote_kind;
    logic [4:0] participant;
    logic [2:0] op;
  } item_t;

  typedef struct packed {
    logic       persist_request;
    logic       reply_dropped;
    logic       protocol_error;
    logic       mixed_result;
    logic [4:0] votes_needed;
  } res_t;

  typedef struct packed {
    logic       protocol_mode;
    logic [4:0] participant_count;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [2:0]       data;
  } mem_wr_t;

  // mode 0 presumed abort, 1 presumed nothing
  function automatic logic [2:0] lookup(input logic mode, input logic [2:0] ps,
                                        input logic [2:0] cs);
    logic [2:0] a;
    a = ACT_CHOKE;
    if (cs <= COORD_WAIT) begin
      unique case (ps)
        PS_BAD: a = ACT_CHOKE;
        PS_PREPARED: a = (cs == COORD_DONE) ? ACT_CHOKE :
                         (cs == COORD_ABORT || cs == COORD_COMMIT) ? ACT_INC : ACT_IGN;
        PS_ABORTED: a = (cs == COORD_COMMIT) ? ACT_CHOKE : ACT_IGN;
        PS_COMMITTED: a = (cs == COORD_ABORT) ? ACT_MIX : ACT_IGN;
        PS_ACTIVE: begin
          if (cs == COORD_VOTE || cs == COORD_ABORT) a = ACT_INC;
          else if (cs == COORD_WAIT && mode) a = ACT_IGN;
          else a = ACT_CHOKE;
        end
        PS_READONLY: a = ACT_IGN;
        PS_DIED: begin
          if (cs == COORD_VOTE) a = ACT_RETX;
          else if (cs == COORD_ABORT || cs == COORD_COMMIT) a = mode ? ACT_RETX : ACT_INC;
          else a = ACT_IGN;
        end
        default: a = ACT_CHOKE;
      endcase
    end
    return a;
  endfunction

endpackage
`default_nettype wire

>>> sv/cpt_state_mem.sv
// Participant state memory, registered read, valid bits cleared at reset.
`default_nettype none
module cpt_state_mem (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [cpt_pkg::IDX_W-1:0] rd_addr,
  output logic [2:0]                   rd_data,
  input  wire cpt_pkg::mem_wr_t        wr
);
  import cpt_pkg::*;

  logic [2:0]                  mem [MAX_PARTICIPANTS];
  logic [MAX_PARTICIPANTS-1:0] valid;
  logic [2:0]                  rd_raw;
  logic                        rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  // entries never written read as bad
  assign rd_data = rd_vld ? rd_raw : PS_BAD;

endmodule
`default_nettype wire

>>> sv/cpt_seq.sv
// Event sequencer: read-modify-write of one entry, or a walk over the configured entries.
`default_nettype none
module cpt_seq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cpt_pkg::cfg_t             cfg,
  input  wire logic                      item_valid,
  output logic                           item_ready,
  input  wire cpt_pkg::item_t            item_in,
  output logic [cpt_pkg::IDX_W-1:0]      rd_addr,
  input  wire logic [2:0]                rd_data,
  output cpt_pkg::mem_wr_t               wr,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output cpt_pkg::res_t                  res
);
  import cpt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVT  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state, state_next;
  item_t            item;
  logic [IDX_W-1:0] cur, cur_next;
  logic [4:0]       needed, needed_next;
  logic             err, err_next;
  logic             dropped, dropped_next;
  logic             persist, persist_next;
  logic             mixed, mixed_next;
  logic [4:0]       n;
  logic             in_range;
  logic [IDX_W-1:0] in_idx;
  logic [2:0]       act;
  logic             accept;

  assign n        = (cfg.participant_count > 5'(MAX_PARTICIPANTS)) ?
                    5'(MAX_PARTICIPANTS) : cfg.participant_count;
  assign in_range = (item_in.participant != 5'd0) && (item_in.participant <= n);
  assign in_idx   = IDX_W'(item_in.participant - 5'd1);
  assign item_ready = (state == ST_IDLE);
  assign accept   = item_valid && item_ready;
  assign act      = lookup(cfg.protocol_mode, rd_data, item.coordinator_state);

  always_comb begin
    unique case (state)
      ST_IDLE: rd_addr = (item_in.op == OP_EVALUATE) ? '0 : in_idx;
      ST_WALK: rd_addr = cur + IDX_W'(1);
      default: rd_addr = cur;
    endcase
  end

  always_comb begin
    state_next   = state;
    cur_next     = cur;
    needed_next  = needed;
    err_next     = err;
    dropped_next = dropped;
    persist_next = persist;
    mixed_next   = mixed;
    wr.en        = 1'b0;
    wr.addr      = cur;
    wr.data      = rd_data;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          needed_next  = '0;
          err_next     = 1'b0;
          dropped_next = 1'b0;
          persist_next = 1'b0;
          cur_next     = '0;
          if (item_in.op <= OP_RECOVER && in_range) begin
            cur_next   = in_idx;
            state_next = ST_EVT;
          end else if (item_in.op == OP_EVALUATE && n != 5'd0) begin
            state_next = ST_WALK;
          end else begin
            err_next   = (item_in.op != OP_EVALUATE);
            state_next = ST_FIN;
          end
        end
      end
      ST_EVT: begin
        state_next = ST_FIN;
        unique case (item.op)
          OP_ACTIVATE: begin
            wr.en   = 1'b1;
            wr.data = PS_ACTIVE;
          end
          OP_VOTE: begin
            if (rd_data == PS_ACTIVE) begin
              wr.en = 1'b1;
              if (item.vote_kind == VK_COMMIT) begin
                wr.data      = PS_PREPARED;
                persist_next = 1'b1;
              end else if (item.vote_kind == VK_READ_ONLY) begin
                wr.data = PS_READONLY;
              end else begin
                wr.data = PS_ABORTED;
              end
            end else if (rd_data == PS_PREPARED || rd_data == PS_ABORTED ||
                         rd_data == PS_COMMITTED || rd_data == PS_READONLY) begin
              dropped_next = 1'b1;
            end else begin
              err_next = 1'b1;
            end
          end
          OP_ACK: begin
            wr.en        = 1'b1;
            wr.data      = item.ack_is_commit ? PS_COMMITTED : PS_ABORTED;
            persist_next = 1'b1;
          end
          OP_DIED: begin
            wr.en   = 1'b1;
            wr.data = PS_DIED;
          end
          default: begin
            if (item.new_state > PS_DIED) begin
              err_next = 1'b1;
            end else begin
              wr.en   = 1'b1;
              wr.data = item.new_state;
            end
          end
        endcase
      end
      ST_WALK: begin
        cur_next = cur + IDX_W'(1);
        if ({1'b0, cur} == n - 5'd1) begin
          state_next = ST_FIN;
        end
        if (act == ACT_CHOKE) begin
          err_next    = 1'b1;
          needed_next = '0;
          state_next  = ST_FIN;
        end else if (act == ACT_MIX) begin
          mixed_next = 1'b1;
        end else if (act == ACT_INC || act == ACT_RETX) begin
          if (act == ACT_RETX && item.zero_on_death) begin
            needed_next = '0;
            state_next  = ST_FIN;
          end else if (needed != 5'd31) begin
            needed_next = needed + 5'd1;
          end
        end
      end
      default: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mixed <= 1'b0;
    end else begin
      state <= state_next;
      mixed <= mixed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
    cur     <= cur_next;
    needed  <= needed_next;
    err     <= err_next;
    dropped <= dropped_next;
    persist <= persist_next;
  end

  assign res_valid           = (state == ST_FIN);
  assign res.votes_needed    = needed;
  assign res.mixed_result    = mixed;
  assign res.protocol_error  = err;
  assign res.reply_dropped   = dropped;
  assign res.persist_request = persist;

endmodule
`default_nettype wire

>>> sv/commit_participant_tracker_core.sv
// Commit participant tracker: config registers, output register, sequencer and state memory.
// Activate, vote, ack, died and recover read their entry, then may write it in the event state
// before the finish state; evaluate walks the configured entries, one entry per cycle,
// through the single memory read port. Invalid items go straight to the finish state.
// One item at a time; the next is taken once the result has moved to the output register.
// Synchronous reset: all participants bad, mixed flag clear, mode 0, count 1.
`default_nettype none
module commit_participant_tracker_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[2:0], participant[7:3], vote_kind[9:8], ack_is_commit[10], new_state[13:11],
  // coordinator_state[16:14], zero_on_death[17], zero[23:18]
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // votes_needed[4:0], mixed_result[5], protocol_error[6], reply_dropped[7],
  // persist_request[8], zero[15:9]
  output logic [15:0]      m_axis_tdata
);
  import cpt_pkg::*;

  cfg_t             cfg;
  item_t            item_in;
  res_t             res;
  logic             res_valid;
  logic             res_ready;
  logic [IDX_W-1:0] rd_addr;
  logic [2:0]       rd_data;
  mem_wr_t          wr;
  res_t             out_word;

  assign item_in = item_t'(s_axis_tdata[$bits(item_t)-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_mode     <= 1'b0;
      cfg.participant_count <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROTOCOL_MODE:     cfg.protocol_mode <= cfg_data[0];
        REG_PARTICIPANT_COUNT: cfg.participant_count <= cfg_data;
        default: ;
      endcase
    end
  end

  cpt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (s_axis_tvalid),
    .item_ready (s_axis_tready),
    .item_in    (item_in),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr         (wr),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  cpt_state_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = {(16 - $bits(res_t))'(0), out_word};

endmodule
`default_nettype wire
